// ===== hdl/sed_pkg.sv =====
// sed_pkg: shared types and constants of the serpentine error-diffusion block.
// Used by the ALU, the RAM wrapper users and the top level. No dependencies.
`timescale 1ns / 1ps
package sed_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int PIX_W     = 13;
  localparam int ERR_W     = 14;
  localparam int WGT_W     = 9;
  localparam int ENTRY_W   = 3 * ERR_W;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [PIX_W-1:0] pix_t;

  // opcodes
  localparam logic [1:0] OP_APPLY = 2'd0;
  localparam logic [1:0] OP_DIST  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // neighbor order of a distribute
  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_BACK  = 2'd1;
  localparam logic [1:0] NB_BELOW = 2'd2;
  localparam logic [1:0] NB_AHEAD = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_W_RIGHT = 3'd4;
  localparam logic [2:0] CFG_W_BACK  = 3'd5;
  localparam logic [2:0] CFG_W_BELOW = 3'd6;
  localparam logic [2:0] CFG_W_AHEAD = 3'd7;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CLAMP,
    ST_NRD,
    ST_NWR,
    ST_ARD,
    ST_AWB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;   // capture operand into the share register
    logic apply;  // 1: pixel add, clamp 0..ONE; 0: weighted share, clamp +-ONE
  } alu_ctl_t;

endpackage

// ===== hdl/sed_ram.sv =====
// sed_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sed_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sed_alu.sv =====
// sed_alu: shared three-lane accumulate unit: weighted share or pixel operand
// is registered, then added to an accumulator and saturated. Uses sed_pkg.
`timescale 1ns / 1ps
module sed_alu (
  input  logic                  clk,
  input  sed_pkg::alu_ctl_t     ctl,
  input  sed_pkg::err_t         val_i [3],
  input  logic [sed_pkg::WGT_W-1:0] weight_i,
  input  sed_pkg::err_t         acc_i [3],
  output sed_pkg::err_t         res_o [3]
);

  localparam logic signed [sed_pkg::ERR_W:0] ONE_S = (sed_pkg::ERR_W+1)'(sed_pkg::ONE);
  localparam logic signed [sed_pkg::ERR_W:0] NEG_S = -ONE_S;

  sed_pkg::err_t share_r [3];
  logic          apply_r;

  logic signed [23:0] prod [3];
  logic signed [sed_pkg::ERR_W:0] sum [3];
  logic signed [sed_pkg::ERR_W:0] lo;

  always_comb begin
    lo = apply_r ? '0 : NEG_S;
    for (int c = 0; c < 3; c++) begin
      prod[c] = 24'(val_i[c]) * 24'($signed({1'b0, weight_i}));
      sum[c]  = {acc_i[c][sed_pkg::ERR_W-1], acc_i[c]}
              + {share_r[c][sed_pkg::ERR_W-1], share_r[c]};
      if (sum[c] < lo) begin
        res_o[c] = sed_pkg::ERR_W'(lo);
      end else if (sum[c] > ONE_S) begin
        res_o[c] = sed_pkg::ERR_W'(ONE_S);
      end else begin
        res_o[c] = sed_pkg::ERR_W'(sum[c]);
      end
    end
  end

  // floor(e*w/256) is bits [21:8] of the product
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      apply_r <= ctl.apply;
      for (int c = 0; c < 3; c++) begin
        share_r[c] <= ctl.apply ? val_i[c] : prod[c][21:8];
      end
    end
  end

endmodule

// ===== hdl/serpentine_error_diffusion_rgb_top.sv =====
// serpentine_error_diffusion_rgb_top: RGB error-diffusion store, sequencer,
// config registers and output register. Uses sed_pkg, sed_alu, sed_ram.
// Apply reads its pixel (ST_ARD) and adds (ST_AWB); distribute clamps, then
// reads and writes 4 neighbors in turn (ST_NRD, ST_NWR); opcode 3 or disabled
// distribute go to ST_OUT. Clear zeroes every entry, one entry per cycle.
// Throughput: one word in flight; in_tready is low until its result is queued.
// Reset (rst_n low, synchronous) loads register defaults and then runs a
// clearing pass over all MAX_WIDTH*MAX_HEIGHT entries with in_tready low.
`timescale 1ns / 1ps
module serpentine_error_diffusion_rgb_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  // cfg
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [12:0]  cfg_wdata,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,  // opcode
  // pos_x[7:0] pos_y[14:8] red_in[27:15] green_in[40:28] blue_in[53:41]
  // red_err[67:54] green_err[81:68] blue_err[95:82] forward_dir[96], zero fill
  input  logic [103:0] in_tdata,
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // red_out[12:0] green_out[25:13] blue_out[38:26], zero fill
  output logic [39:0]  out_tdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = sed_pkg::ERR_W;

  // config registers
  logic        en_r;
  logic [8:0]  fw_r;
  logic [7:0]  fh_r;
  logic [12:0] lim_r;
  logic [8:0]  w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      fw_r   <= 9'd256;
      fh_r   <= 8'd128;
      lim_r  <= 13'd4096;
      w_r[0] <= 9'd112;
      w_r[1] <= 9'd48;
      w_r[2] <= 9'd80;
      w_r[3] <= 9'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        sed_pkg::CFG_ENABLE:  en_r   <= cfg_wdata[0];
        sed_pkg::CFG_WIDTH:   fw_r   <= cfg_wdata[8:0];
        sed_pkg::CFG_HEIGHT:  fh_r   <= cfg_wdata[7:0];
        sed_pkg::CFG_LIMIT:   lim_r  <= cfg_wdata;
        sed_pkg::CFG_W_RIGHT: w_r[0] <= cfg_wdata[8:0];
        sed_pkg::CFG_W_BACK:  w_r[1] <= cfg_wdata[8:0];
        sed_pkg::CFG_W_BELOW: w_r[2] <= cfg_wdata[8:0];
        sed_pkg::CFG_W_AHEAD: w_r[3] <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  sed_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          clr_reply_r, clr_reply_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [39:0]   out_data_r, out_data_nxt;

  // word registers (payload, no reset)
  logic [7:0]    x_r;
  logic [6:0]    y_r;
  logic          fwd_r;
  sed_pkg::pix_t rgb_r [3];
  sed_pkg::err_t err_r [3];
  sed_pkg::pix_t res_r [3];
  logic          nb_in_r;
  logic [AW-1:0] nb_addr_r;

  // RAM
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [sed_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  sed_ram #(.WIDTH(sed_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared ALU
  sed_pkg::alu_ctl_t alu_ctl;
  sed_pkg::err_t     alu_val [3];
  sed_pkg::err_t     alu_acc [3];
  sed_pkg::err_t     alu_res [3];
  logic [8:0]        wsel;

  sed_alu u_alu (
    .clk     (clk),
    .ctl     (alu_ctl),
    .val_i   (alu_val),
    .weight_i(wsel),
    .acc_i   (alu_acc),
    .res_o   (alu_res)
  );

  // target pixel: the word's own pixel for apply, else neighbor k_r
  logic signed [9:0] xs, dx, tx;
  logic [7:0]        ty;
  logic              tgt_ok;
  logic [31:0]       addr_full;

  always_comb begin
    xs = $signed({2'b00, x_r});
    dx = fwd_r ? 10'sd1 : -10'sd1;
    tx = xs;
    ty = {1'b0, y_r} + 8'd1;
    if (state_r == sed_pkg::ST_ARD) begin
      ty = {1'b0, y_r};
    end else begin
      case (k_r)
        sed_pkg::NB_RIGHT: begin
          tx = xs + dx;
          ty = {1'b0, y_r};
        end
        sed_pkg::NB_BACK:  tx = xs - dx;
        sed_pkg::NB_BELOW: tx = xs;
        default:           tx = xs + dx;
      endcase
    end
    tgt_ok = !tx[9]
          && (32'(tx[8:0]) < 32'(fw_r)) && (32'(tx[8:0]) < 32'(MAX_WIDTH))
          && (32'(ty) < 32'(fh_r)) && (32'(ty) < 32'(MAX_HEIGHT));
    addr_full = 32'(ty) * 32'(MAX_WIDTH) + 32'(tx[8:0]);
    wsel = (w_r[k_r] > 9'd256) ? 9'd256 : w_r[k_r];
  end

  // incoming error clamp
  logic [12:0]       lim;
  logic signed [EW:0] lim_p, lim_n, ev [3];
  sed_pkg::err_t     err_cl [3];

  always_comb begin
    lim   = (lim_r > 13'd4096) ? 13'd4096 : lim_r;
    lim_p = $signed({2'b00, lim});
    lim_n = -lim_p;
    for (int c = 0; c < 3; c++) begin
      ev[c] = {err_r[c][EW-1], err_r[c]};
      if (ev[c] < lim_n) begin
        err_cl[c] = EW'(lim_n);
      end else if (ev[c] > lim_p) begin
        err_cl[c] = EW'(lim_p);
      end else begin
        err_cl[c] = err_r[c];
      end
    end
  end

  logic in_acc;
  assign in_tready = (state_r == sed_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    alu_ctl       = '0;
    ram_we        = 1'b0;
    ram_waddr     = nb_addr_r;
    ram_raddr     = addr_full[AW-1:0];
    for (int c = 0; c < 3; c++) begin
      alu_val[c] = alu_ctl.apply ? EW'(rgb_r[c]) : err_r[c];
      alu_acc[c] = ram_rdata[c*EW +: EW];
      ram_wdata[c*EW +: EW] = alu_res[c];
    end
    case (state_r)
      sed_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt   = '0;
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? sed_pkg::ST_OUT : sed_pkg::ST_IDLE;
        end
      end
      sed_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            sed_pkg::OP_APPLY: state_nxt = sed_pkg::ST_ARD;
            sed_pkg::OP_DIST:  state_nxt = en_r ? sed_pkg::ST_CLAMP : sed_pkg::ST_OUT;
            sed_pkg::OP_CLEAR: begin
              state_nxt     = sed_pkg::ST_CLR;
              clr_reply_nxt = 1'b1;
            end
            default:           state_nxt = sed_pkg::ST_OUT;
          endcase
        end
      end
      sed_pkg::ST_CLAMP: begin
        k_nxt     = sed_pkg::NB_RIGHT;
        state_nxt = sed_pkg::ST_NRD;
      end
      sed_pkg::ST_NRD: begin
        alu_ctl.load = 1'b1;
        state_nxt    = sed_pkg::ST_NWR;
      end
      sed_pkg::ST_NWR: begin
        ram_we = nb_in_r;
        k_nxt  = k_r + 2'd1;
        state_nxt = (k_r == sed_pkg::NB_AHEAD) ? sed_pkg::ST_OUT : sed_pkg::ST_NRD;
      end
      sed_pkg::ST_ARD: begin
        alu_ctl.load  = 1'b1;
        alu_ctl.apply = 1'b1;
        for (int c = 0; c < 3; c++) begin
          alu_val[c] = EW'(rgb_r[c]);
        end
        state_nxt = sed_pkg::ST_AWB;
      end
      sed_pkg::ST_AWB: begin
        for (int c = 0; c < 3; c++) begin
          alu_acc[c] = (nb_in_r && en_r) ? ram_rdata[c*EW +: EW] : '0;
        end
        state_nxt = sed_pkg::ST_OUT;
      end
      sed_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_r[2], res_r[1], res_r[0]};
          state_nxt     = sed_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sed_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sed_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      k_r         <= k_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      x_r      <= in_tdata[7:0];
      y_r      <= in_tdata[14:8];
      rgb_r[0] <= in_tdata[27:15];
      rgb_r[1] <= in_tdata[40:28];
      rgb_r[2] <= in_tdata[53:41];
      err_r[0] <= in_tdata[67:54];
      err_r[1] <= in_tdata[81:68];
      err_r[2] <= in_tdata[95:82];
      fwd_r    <= in_tdata[96];
      for (int c = 0; c < 3; c++) begin
        res_r[c] <= '0;
      end
    end
    if (state_r == sed_pkg::ST_CLAMP) begin
      for (int c = 0; c < 3; c++) begin
        err_r[c] <= err_cl[c];
      end
    end
    if (state_r == sed_pkg::ST_NRD || state_r == sed_pkg::ST_ARD) begin
      nb_in_r   <= tgt_ok;
      nb_addr_r <= addr_full[AW-1:0];
    end
    if (state_r == sed_pkg::ST_AWB) begin
      for (int c = 0; c < 3; c++) begin
        res_r[c] <= en_r ? alu_res[c][sed_pkg::PIX_W-1:0] : rgb_r[c];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/sed_checker.sv =====
// sed_checker: port-level assertions for serpentine_error_diffusion_rgb_top,
// attached by bind. Depends on the top level's port names only.
`timescale 1ns / 1ps
module sed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted word");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("not clearing after reset");

endmodule

bind serpentine_error_diffusion_rgb_top sed_checker u_sed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== tb/serpentine_error_diffusion_rgb_top_tb.sv =====
// serpentine_error_diffusion_rgb_top_tb: self-checking bench for the RGB error-diffusion store.
// A directed table, then serpentine pixel walks over several register settings, scored
// against a behavioral predictor or typed expectations. Depends on sed_pkg and top level only.
`timescale 1ns / 1ps
module serpentine_error_diffusion_rgb_top_tb;

  localparam int STORE_W    = 256;
  localparam int STORE_H    = 128;
  localparam int DEPTH      = STORE_W * STORE_H;
  localparam int RUN_LIMIT  = 2_000_000;  // cycles; clears dominate
  localparam int SETTLE     = 24;         // wait after the last expected output
  localparam int PHASE_LEN  = 55;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] op;
    int         x, y, r, g, b, er, eg, eb, dir;
    bit         typed;      // expectation typed in below
    sed_pkg::pix_t xr, xg, xb;
  } plan_row_t;

  typedef struct packed {
    sed_pkg::pix_t r, g, b;
  } pixel_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [12:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;   // opcode
  // pos_x[7:0] pos_y[14:8] red_in[27:15] green_in[40:28] blue_in[53:41]
  // red_err[67:54] green_err[81:68] blue_err[95:82] forward_dir[96]
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // red_out[12:0] green_out[25:13] blue_out[38:26]
  logic [39:0]  out_tdata;

  serpentine_error_diffusion_rgb_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers and per-pixel error accumulators
  // ---------------------------------------------------------------------------
  int  err_acc [3][DEPTH];
  int  sh_enable, sh_width, sh_height, sh_limit;
  int  sh_weight [4];   // right, below-back, below, below-ahead

  pixel_t pixels_due [$];   // outputs still owed by the block
  int     mismatches = 0;
  int     cycles = 0;
  int     tx_idle = 28, rx_idle = 85;
  plan_row_t plan [$];

  function automatic void wipe_store();
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < DEPTH; i++) err_acc[c][i] = 0;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // pixel index, or -1 when outside the active frame
  function automatic int pixel_index(int x, int y);
    int w, h;
    w = sh_width < STORE_W ? sh_width : STORE_W;
    h = sh_height < STORE_H ? sh_height : STORE_H;
    if (x < 0 || y < 0 || x >= w || y >= h) return -1;
    return y * STORE_W + x;
  endfunction

  // floor(e * w / 256), weight saturating at 256
  function automatic void spread(int x, int y, int e [3], int wt);
    int idx, p;
    idx = pixel_index(x, y);
    if (idx < 0) return;
    for (int c = 0; c < 3; c++) begin
      p = e[c] * (wt > 256 ? 256 : wt);
      err_acc[c][idx] = clip(err_acc[c][idx] + (p >>> 8), -sed_pkg::ONE, sed_pkg::ONE);
    end
  endfunction

  function automatic pixel_t diffuse_step(logic [1:0] op, int x, int y, int r, int g, int b,
                                          int er, int eg, int eb, int dir);
    pixel_t res;
    int     v [3], e [3], idx, lim, dx;
    res = '{default: '0};
    if (op == sed_pkg::OP_APPLY) begin
      v = '{r & 'h1FFF, g & 'h1FFF, b & 'h1FFF};
      if (sh_enable != 0) begin
        idx = pixel_index(x, y);
        for (int c = 0; c < 3; c++)
          v[c] = clip(v[c] + (idx < 0 ? 0 : err_acc[c][idx]), 0, sed_pkg::ONE);
      end
      res = '{sed_pkg::pix_t'(v[0]), sed_pkg::pix_t'(v[1]), sed_pkg::pix_t'(v[2])};
    end else if (op == sed_pkg::OP_DIST) begin
      if (sh_enable != 0) begin
        lim = sh_limit > sed_pkg::ONE ? sed_pkg::ONE : sh_limit;
        dx  = dir ? 1 : -1;
        e[0] = clip(int'(sed_pkg::err_t'(er)), -lim, lim);
        e[1] = clip(int'(sed_pkg::err_t'(eg)), -lim, lim);
        e[2] = clip(int'(sed_pkg::err_t'(eb)), -lim, lim);
        spread(x + dx, y,     e, sh_weight[0]);
        spread(x - dx, y + 1, e, sh_weight[1]);
        spread(x,      y + 1, e, sh_weight[2]);
        spread(x + dx, y + 1, e, sh_weight[3]);
      end
    end else if (op == sed_pkg::OP_CLEAR) begin
      wipe_store();
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_word(logic [1:0] op, int x, int y, int r, int g, int b,
                           int er, int eg, int eb, int dir, bit typed, pixel_t typed_px);
    pixel_t px;
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, dir[0], eb[13:0], eg[13:0], er[13:0], b[12:0], g[12:0], r[12:0],
                  y[6:0], x[7:0]};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    px = diffuse_step(op, x, y, r, g, b, er, eg, eb, dir);
    if (typed) px = typed_px;
    pixels_due.insert(pixels_due.size(), px);
  endtask

  // idle the input and wait until the block has nothing left in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[12:0];
    @(posedge clk);
    case (idx)
      sed_pkg::CFG_ENABLE:  sh_enable    = val & 1;
      sed_pkg::CFG_WIDTH:   sh_width     = val & 'h1FF;
      sed_pkg::CFG_HEIGHT:  sh_height    = val & 'hFF;
      sed_pkg::CFG_LIMIT:   sh_limit     = val & 'h1FFF;
      sed_pkg::CFG_W_RIGHT: sh_weight[0] = val & 'h1FF;
      sed_pkg::CFG_W_BACK:  sh_weight[1] = val & 'h1FF;
      sed_pkg::CFG_W_BELOW: sh_weight[2] = val & 'h1FF;
      default:              sh_weight[3] = val & 'h1FF;
    endcase
  endtask

  task automatic program_all(int en, int fw, int fh, int lim, int w0, int w1, int w2, int w3);
    drain();
    write_reg(sed_pkg::CFG_ENABLE, en);
    write_reg(sed_pkg::CFG_WIDTH, fw);
    write_reg(sed_pkg::CFG_HEIGHT, fh);
    write_reg(sed_pkg::CFG_LIMIT, lim);
    write_reg(sed_pkg::CFG_W_RIGHT, w0);
    write_reg(sed_pkg::CFG_W_BACK, w1);
    write_reg(sed_pkg::CFG_W_BELOW, w2);
    write_reg(sed_pkg::CFG_W_AHEAD, w3);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(logic [1:0] op, int x, int y, int r, int g, int b,
                                  int er, int eg, int eb, int dir,
                                  bit typed = 0, int xr = 0, int xg = 0, int xb = 0);
    plan_row_t row;
    row = '{ROW_WORD, op, x, y, r, g, b, er, eg, eb, dir, typed,
            sed_pkg::pix_t'(xr), sed_pkg::pix_t'(xg), sed_pkg::pix_t'(xb)};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, int val);
    plan_row_t row;
    row = '{ROW_CFG, 2'd0, idx, val, 0, 0, 0, 0, 0, 0, 0, 0, '0, '0, '0};
    plan.insert(plan.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: sample at the falling edge, the word moves on the next rise
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    out_tready <= (rx_idle == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle);

  always @(negedge clk) begin
    pixel_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[12:0], out_tdata[25:13], out_tdata[38:26]};
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", out_tdata);
      end else begin
        want = pixels_due.pop_front();
        if (got != want || out_tdata[39] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.r, want.g, want.b, got.r, got.g, got.b);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    pixel_t none;
    int     sent, clears, cx, cy, cdir, fw, fh, r, g, b, er, eg, eb;
    none = '{default: '0};
    sent = 0;
    clears = 0;

    wipe_store();
    sh_enable = 1; sh_width = 256; sh_height = 128; sh_limit = 4096;
    sh_weight = '{112, 48, 80, 16};

    // Directed: extremes, every opcode, frame edges, saturation, disable.
    add_row(sed_pkg::OP_APPLY, 0, 0, 0, 4096, 2048, 0, 0, 0, 1, 1, 0, 4096, 2048); // empty
    add_row(sed_pkg::OP_APPLY, 255, 127, 8191, 4097, 1, 0, 0, 0, 0, 1, 4096, 4096, 1);
    add_row(sed_pkg::OP_DIST, 0, 0, 0, 0, 0, 4096, -4096, 8191, 1, 1);       // limit clamps
    add_row(sed_pkg::OP_APPLY, 1, 0, 2048, 2048, 2048, 0, 0, 0, 0);
    add_row(sed_pkg::OP_APPLY, 0, 1, 2048, 2048, 2048, 0, 0, 0, 0);
    add_row(sed_pkg::OP_APPLY, 1, 1, 2048, 2048, 2048, 0, 0, 0, 0);
    add_row(sed_pkg::OP_DIST, 0, 0, 0, 0, 0, -4096, 4096, -1, 0, 1);         // left edge
    add_row(sed_pkg::OP_DIST, 255, 127, 0, 0, 0, -8192, 8191, 0, 1, 1);      // far corner
    add_row(sed_pkg::OP_DIST, 0, 0, 0, 0, 0, 4096, 4096, -4096, 1, 1);
    add_row(sed_pkg::OP_DIST, 0, 0, 0, 0, 0, 4096, 4096, -4096, 1, 1);
    add_row(sed_pkg::OP_DIST, 0, 0, 0, 0, 0, 4096, 4096, -4096, 1, 1);       // saturates
    add_row(sed_pkg::OP_APPLY, 1, 0, 0, 4096, 4096, 0, 0, 0, 0);
    add_row(sed_pkg::OP_APPLY, 255, 127, 100, 200, 300, 0, 0, 0, 0);
    add_row(2'd3, 7, 7, 8191, 8191, 8191, 8191, 8191, 8191, 1, 1);           // unused opcode
    add_row(sed_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(sed_pkg::OP_APPLY, 1, 0, 100, 0, 4096, 0, 0, 0, 0, 1, 100, 0, 4096); // empty again
    add_cfg(sed_pkg::CFG_ENABLE, 0);
    add_row(sed_pkg::OP_APPLY, 3, 3, 8191, 0, 4096, 0, 0, 0, 0, 1, 8191, 0, 4096); // pass
    add_row(sed_pkg::OP_DIST, 3, 3, 0, 0, 0, 4096, 4096, 4096, 1, 1);        // ignored
    add_cfg(sed_pkg::CFG_ENABLE, 1);
    add_row(sed_pkg::OP_APPLY, 4, 3, 1000, 1000, 1000, 0, 0, 0, 0, 1, 1000, 1000, 1000);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].op | 3'(plan[i].x), plan[i].y);
        cfg_we <= 1'b0;
      end else begin
        send_word(plan[i].op, plan[i].x, plan[i].y, plan[i].r, plan[i].g, plan[i].b,
                  plan[i].er, plan[i].eg, plan[i].eb, plan[i].dir, plan[i].typed,
                  '{plan[i].xr, plan[i].xg, plan[i].xb});
        sent++;
      end
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_all(1, 8, 4, 4096, 112, 48, 80, 16);
        1: program_all(1, 1, 1, 0, 0, 0, 0, 0);
        2: program_all(1, 511, 255, 8191, 511, 256, 511, 256);
        3: program_all(0, 5, 3, 2048, 100, 100, 100, 100);
        4: program_all(1, 0, 0, $urandom_range(8191), $urandom_range(511), $urandom_range(511),
                       $urandom_range(511), $urandom_range(511));
        default: program_all(1, $urandom_range(16, 2), $urandom_range(8, 2), $urandom_range(8191),
                             $urandom_range(511), $urandom_range(511), $urandom_range(511),
                             $urandom_range(511));
      endcase
      fw = sh_width < STORE_W ? sh_width : STORE_W;
      fh = sh_height < STORE_H ? sh_height : STORE_H;
      if (ph == 2) begin  // big frame: walk a small corner of it
        fw = 6;
        fh = 3;
      end
      cx = 0; cy = 0; cdir = 1;
      for (int k = 0; k < PHASE_LEN; k++) begin
        // pacing: receiver mostly idles, then sender mostly idles, then neither
        if (sent < 220) begin tx_idle = 28; rx_idle = 85; end
        else if (sent < 420) begin tx_idle = 85; rx_idle = 28; end
        else begin tx_idle = 0; rx_idle = 0; end
        if (ph == 0 && k == 50) drain();  // one full pause with nothing in flight

        if (fw == 0 || fh == 0 || $urandom_range(9) == 0) begin
          // noise: any opcode, every field over its whole width
          automatic logic [1:0] op = 2'($urandom_range(3));
          if (op == sed_pkg::OP_CLEAR && (clears >= 2 || $urandom_range(3) != 0))
            op = sed_pkg::OP_APPLY;
          if (op == sed_pkg::OP_CLEAR) clears++;
          send_word(op, $urandom_range(255), $urandom_range(127), $urandom_range(8191),
                    $urandom_range(8191), $urandom_range(8191), $urandom_range(16383),
                    $urandom_range(16383), $urandom_range(16383), $urandom_range(1), 0, none);
        end else begin
          // serpentine walk: apply the pixel, then spread its quantization error
          r = $urandom_range(4096); g = $urandom_range(4096); b = $urandom_range(4096);
          send_word(sed_pkg::OP_APPLY, cx, cy, r, g, b, 0, 0, 0, 0, 0, none);
          er = $urandom_range(8192) - 4096;
          eg = $urandom_range(8192) - 4096;
          eb = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(8192) - 4096;
          send_word(sed_pkg::OP_DIST, cx, cy, 0, 0, 0, er, eg, eb, cdir, 0, none);
          sent++;
          cx += cdir ? 1 : -1;
          if (cx < 0 || cx >= fw) begin
            cx   = cdir ? fw - 1 : 0;
            cdir = !cdir;
            cy   = (cy + 1) % fh;
          end
        end
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
